// File: design/ptrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptrc_pkg;

	localparam logic [2:0] KIND_SECTION = 3'd0;
	localparam logic [2:0] KIND_SMALL   = 3'd1;
	localparam logic [2:0] KIND_LARGE   = 3'd2;
	localparam logic [2:0] KIND_BAD_L1  = 3'd3;
	localparam logic [2:0] KIND_BAD_L2  = 3'd4;
	localparam logic [2:0] KIND_LOW_PTR = 3'd5;

	localparam logic [2:0] ACC_PRIV_R   = 3'd4;
	localparam logic [2:0] ACC_ALL_R    = 3'd5;
	localparam logic [2:0] ACC_UNKNOWN  = 3'd6;

	localparam logic [1:0] DESC_FAULT   = 2'd0;
	localparam logic [1:0] DESC_COARSE  = 2'd1;
	localparam logic [1:0] DESC_SECTION = 2'd2;
	localparam logic [1:0] DESC_RSVD    = 2'd3;

	localparam logic [31:0] SECTION_PA_MASK = 32'hFFF0_0000;
	localparam logic [31:0] SMALL_PA_MASK   = 32'hFFFF_F000;
	localparam logic [31:0] LARGE_PA_MASK   = 32'hFFFF_0000;
	localparam logic [31:0] COARSE_PTR_MASK = 32'hFFFF_FFC0;
	localparam logic [31:0] SECTION_SIZE    = 32'h0010_0000;
	localparam logic [31:0] LARGE_SIZE      = 32'h0001_0000;
	localparam logic [31:0] SMALL_SIZE      = 32'h0000_1000;
	localparam logic [31:0] L2_BASE_RESET   = 32'h1FFF_5000;

	localparam logic [3:0]  LARGE_COPIES    = 4'd15;
	localparam logic [11:0] L1_LAST         = 12'hFFF;
	localparam logic [7:0]  L2_LAST         = 8'hFF;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic        mode;
		logic [11:0] l1_index;
		logic [7:0]  l2_index;
		logic [31:0] descriptor;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [31:0] va;
		logic [31:0] pa;
		logic [31:0] size;
		logic [19:0] attr;
	} run_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] va_start;
		logic [31:0] va_end;
		logic [31:0] pa_start;
		logic [31:0] pa_end;
		logic        exec_never;
		logic [2:0]  access_class;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic [2:0] access_of(input logic apx, input logic [1:0] ap);
		logic [2:0] ac;
		if (!apx) begin
			ac = {1'b0, ap};
		end else begin
			case (ap) inside
				2'd1: ac = ACC_PRIV_R;
				2'd2, 2'd3: ac = ACC_ALL_R;
				default: ac = ACC_UNKNOWN;
			endcase
		end
		return ac;
	endfunction

	function automatic res_t run_result(input run_t r);
		res_t o;
		logic [19:0] a;
		a = r.attr;
		o = '0;
		o.kind = {1'b0, r.kind};
		o.va_start = r.va;
		o.va_end = r.va + r.size;
		o.pa_start = r.pa;
		o.pa_end = r.pa + r.size;
		if (r.kind == KIND_SECTION[1:0]) begin
			o.exec_never = a[4];
			o.access_class = access_of(a[15], a[11:10]);
		end else begin
			o.exec_never = (r.kind == KIND_SMALL[1:0]) ? a[0] : a[15];
			o.access_class = access_of(a[9], a[5:4]);
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// File: design/ptrc_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ptrc_decode (
	input  var ptrc_pkg::item_t item,
	input  var ptrc_pkg::run_t  run_q,
	input  var logic [3:0]      skip_q,
	input  var logic [31:0]     l2_table_base,
	output ptrc_pkg::run_t      run_n,
	output logic [3:0]          skip_n,
	output ptrc_pkg::push_t     push
);
	import ptrc_pkg::*;

	logic [31:0] va_l1;
	logic [31:0] va_l2;
	logic [31:0] d;
	logic [31:0] ptr;
	logic [31:0] run_va_end;
	logic [31:0] run_pa_end;
	logic        do_map;
	logic [1:0]  cand_kind;
	logic [31:0] cand_va;
	logic [31:0] cand_pa;
	logic [31:0] cand_size;
	logic [19:0] cand_attr;
	logic        extend;
	logic        flush_old;
	logic        err_v;
	res_t        err;
	logic        at_end;
	run_t        run_mid;
	logic        res_a;
	logic        res_c;
	res_t        old_res;
	res_t        mid_res;

	assign d          = item.descriptor;
	assign va_l1      = {item.l1_index, 20'd0};
	assign va_l2      = {item.l1_index, item.l2_index, 12'd0};
	assign ptr        = d & COARSE_PTR_MASK;
	assign run_va_end = run_q.va + run_q.size;
	assign run_pa_end = run_q.pa + run_q.size;

	always_comb begin
		do_map    = 1'b0;
		cand_kind = KIND_SECTION[1:0];
		cand_va   = va_l1;
		cand_pa   = d & SECTION_PA_MASK;
		cand_size = SECTION_SIZE;
		cand_attr = d[19:0];
		flush_old = 1'b0;
		err_v     = 1'b0;
		err       = '0;
		skip_n    = skip_q;
		at_end    = 1'b0;
		if (!item.mode) begin
			skip_n = '0;
			at_end = (item.l1_index == L1_LAST);
			unique case (d[1:0])
				DESC_SECTION: begin
					do_map = 1'b1;
				end
				DESC_COARSE: begin
					flush_old = 1'b1;
					if (ptr < l2_table_base) begin
						err_v = 1'b1;
						err.kind = KIND_LOW_PTR;
						err.va_start = va_l1;
						err.pa_start = ptr;
					end
				end
				DESC_FAULT, DESC_RSVD: begin
					flush_old = 1'b1;
					if (d != '0) begin
						err_v = 1'b1;
						err.kind = KIND_BAD_L1;
						err.va_start = va_l1;
					end
				end
				default: ;
			endcase
		end else begin
			at_end  = (item.l2_index == L2_LAST);
			cand_va = va_l2;
			if (skip_q != '0) begin
				skip_n = skip_q - 4'd1;
			end else if (d[1]) begin
				do_map    = 1'b1;
				cand_kind = KIND_SMALL[1:0];
				cand_pa   = d & SMALL_PA_MASK;
				cand_size = SMALL_SIZE;
				cand_attr = {8'd0, d[11:0]};
			end else if (d[0]) begin
				do_map    = 1'b1;
				cand_kind = KIND_LARGE[1:0];
				cand_pa   = d & LARGE_PA_MASK;
				cand_size = LARGE_SIZE;
				cand_attr = {4'd0, d[15:0]};
				skip_n    = LARGE_COPIES;
			end else begin
				flush_old = 1'b1;
				if (d != '0) begin
					err_v = 1'b1;
					err.kind = KIND_BAD_L2;
					err.va_start = va_l2;
				end
			end
			if (at_end) begin
				skip_n = '0;
			end
		end
	end

	assign extend = run_q.valid && run_q.kind == cand_kind && run_q.attr == cand_attr
		&& cand_pa == run_pa_end && cand_va == run_va_end;

	always_comb begin
		run_mid = run_q;
		if (do_map && extend) begin
			run_mid.size = run_q.size + cand_size;
		end else if (do_map) begin
			run_mid.valid = 1'b1;
			run_mid.kind  = cand_kind;
			run_mid.va    = cand_va;
			run_mid.pa    = cand_pa;
			run_mid.size  = cand_size;
			run_mid.attr  = cand_attr;
		end else if (flush_old) begin
			run_mid.valid = 1'b0;
		end
	end

	assign res_a   = run_q.valid && (flush_old || (do_map && !extend));
	assign res_c   = at_end && run_mid.valid;
	assign old_res = run_result(run_q);
	assign mid_res = run_result(run_mid);

	always_comb begin
		run_n = run_mid;
		if (at_end) begin
			run_n.valid = 1'b0;
		end
		push.n  = 2'({1'b0, res_a} + {1'b0, err_v} + {1'b0, res_c});
		push.r0 = res_a ? old_res : (err_v ? err : mid_res);
		push.r1 = err_v ? err : mid_res;
		push.r0.last = (push.n == 2'd1);
		push.r1.last = 1'b1;
	end

endmodule

`default_nettype wire

// File: design/ptrc_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ptrc_out_queue #(
	parameter int DEPTH = ptrc_pkg::QUEUE_DEPTH_DEF
) (
	input  var logic                      clk,
	input  var logic                      arst_n,
	input  var ptrc_pkg::push_t           push,
	input  var logic                      pop,
	output ptrc_pkg::res_t                head,
	output logic [$clog2(DEPTH+1)-1:0]    count
);
	import ptrc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_1;
	logic [PTR_W-1:0] wr_ptr_2;

	function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_1 = inc(wr_ptr_q);
	assign wr_ptr_2 = inc(wr_ptr_1);
	assign head     = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.n)
				2'd1: wr_ptr_q <= wr_ptr_1;
				2'd2: wr_ptr_q <= wr_ptr_2;
				default: ;
			endcase
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// File: design/page_table_range_coalescer.sv
// Path: an accepted descriptor is registered in the input stage, decoded, and its
// results written to the output queue. Throughput: 1 descriptor per cycle while
// the output queue has two free entries; results leave at 1 per cycle while
// out_ready is high, so two-result inputs or a low out_ready can stall input.
// Reset: run state and copy skip cleared, queue empty, l2_table_base 0x1FFF5000.
`timescale 1ns / 1ps
`default_nettype none

module page_table_range_coalescer #(
	parameter int QUEUE_DEPTH = ptrc_pkg::QUEUE_DEPTH_DEF
) (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        cfg_we,
	input  var logic [31:0] cfg_wdata,
	input  var logic        in_valid,
	output logic            in_ready,
	input  var logic        mode,
	input  var logic [11:0] l1_index,
	input  var logic [7:0]  l2_index,
	input  var logic [31:0] descriptor,
	output logic            out_valid,
	input  var logic        out_ready,
	output logic [2:0]      kind,
	output logic [31:0]     va_start,
	output logic [31:0]     va_end,
	output logic [31:0]     pa_start,
	output logic [31:0]     pa_end,
	output logic            exec_never,
	output logic [2:0]      access_class,
	output logic            last
);
	import ptrc_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             valid_s1;
	item_t            item_s1;
	run_t             run_q;
	logic [3:0]       skip_q;
	logic [31:0]      base_q;
	run_t             run_n;
	logic [3:0]       skip_n;
	push_t            push_d;
	push_t            push_q;
	res_t             head;
	logic [CNT_W-1:0] count;
	logic             take_s1;
	logic             pop;

	assign take_s1  = valid_s1 && (count <= CNT_W'(QUEUE_DEPTH - 2));
	assign in_ready = !valid_s1 || take_s1;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			run_q    <= '0;
			skip_q   <= '0;
			base_q   <= L2_BASE_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (take_s1) begin
				run_q  <= run_n;
				skip_q <= skip_n;
			end
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{mode: mode, l1_index: l1_index, l2_index: l2_index,
				descriptor: descriptor};
		end
	end

	ptrc_decode u_decode (
		.item          (item_s1),
		.run_q         (run_q),
		.skip_q        (skip_q),
		.l2_table_base (base_q),
		.run_n         (run_n),
		.skip_n        (skip_n),
		.push          (push_d)
	);

	always_comb begin
		push_q = push_d;
		if (!take_s1) begin
			push_q.n = 2'd0;
		end
	end

	ptrc_out_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push_q),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	assign out_valid    = (count != '0);
	assign kind         = head.kind;
	assign va_start     = head.va_start;
	assign va_end       = head.va_end;
	assign pa_start     = head.pa_start;
	assign pa_end       = head.pa_end;
	assign exec_never   = head.exec_never;
	assign access_class = head.access_class;
	assign last         = head.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(QUEUE_DEPTH))
		else $error("output queue overflow");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with empty stage");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= KIND_LOW_PTR)
		else $error("result kind out of range");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_BAD_L1 || kind == KIND_BAD_L2 || kind == KIND_LOW_PTR)
		|-> va_end == '0 && pa_end == '0 && !exec_never && access_class == '0)
		else $error("error result carries range fields");

	a_no_push_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> count <= $past(count))
		else $error("result queued without an item");

endmodule

`default_nettype wire
